>>> rtl/core/bdq_pkg.sv
// Shared constants for the bounded deque with search: sizes, operation codes
// and status codes. No dependencies.
package bdq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W      = $clog2(DEPTH);

  localparam logic [2:0] FuncPushFront = 3'd0;
  localparam logic [2:0] FuncPushBack  = 3'd1;
  localparam logic [2:0] FuncPopFront  = 3'd2;
  localparam logic [2:0] FuncPopBack   = 3'd3;
  localparam logic [2:0] FuncContains  = 3'd4;
  localparam logic [2:0] FuncRemove    = 3'd5;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  typedef struct packed {
    logic load;
    logic cmp;
    logic apply;
  } bdq_cmd_t;

endpackage

>>> rtl/core/bounded_deque_with_search_unit.sv
// Bounded deque with search: top level joining controller and datapath.
// Depends on bdq_pkg, bdq_ctrl and bdq_dp.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction: an
//   operation code func_i and a signed value data_value_i. Operations are
//   push front, push back, pop front, pop back, contains and remove first
//   match. Output channel (out_valid_o / out_stall_i) returns one result per
//   transaction: status, found flag, front and back entries, entry count.
//   A transaction passes the load, compare and apply steps of the controller
//   in order; its result is registered in the apply step once the output
//   is free. A new transaction is taken only after the apply step of the
//   last; the match compare over all sixteen cells is registered before the
//   shift network. The next transaction is taken while an earlier result
//   still waits. Reset empties the deque and drops any pending result; cell
//   contents stay undefined until written. When the receiver stalls, the
//   result holds and the apply step of the following transaction waits.
module bounded_deque_with_search_unit
  import bdq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            func_i,
  input  logic [VALUE_BITS-1:0] data_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            status_o,
  output logic                  found_o,
  output logic [VALUE_BITS-1:0] front_value_o,
  output logic [VALUE_BITS-1:0] back_value_o,
  output logic [CNT_W-1:0]      entry_count_o
);

  bdq_cmd_t cmd;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  bdq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func_i),
    .data_value_i  (data_value_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .entry_count_o (entry_count_o)
  );

endmodule

>>> rtl/core/bdq_ctrl.sv
// Sequencing state machine for the deque: load, compare, apply, and the
// result valid flag. Depends on bdq_pkg.
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bdq_cmd_t cmd_o
);

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SCmp   = 2'd1;
  localparam logic [1:0] SApply = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign in_stall_o  = (state_q != SIdle);
  assign accept      = in_valid_i && (state_q == SIdle);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = SCmp;
        end
      end
      SCmp: begin
        cmd_o.cmp = 1'b1;
        state_d   = SApply;
      end
      SApply: begin
        if (out_free) begin
          cmd_o.apply = 1'b1;
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == SCmp)
    else $error("accepted transaction did not advance to compare");

  a_rise_from_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == SApply)
    else $error("result valid rose outside apply");

  a_apply_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.apply |-> (!out_valid_q || !out_stall_i))
    else $error("apply would overwrite a stalled result");

endmodule

>>> rtl/core/bdq_dp.sv
// Datapath of the deque: sixteen register cells, parallel match compare,
// shift network and result registers. Depends on bdq_pkg.
module bdq_dp
  import bdq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bdq_cmd_t               cmd_i,
  input  logic [2:0]             func_i,
  input  logic [VALUE_BITS-1:0]  data_value_i,
  output logic [1:0]             status_o,
  output logic                   found_o,
  output logic [VALUE_BITS-1:0]  front_value_o,
  output logic [VALUE_BITS-1:0]  back_value_o,
  output logic [CNT_W-1:0]       entry_count_o
);

  logic [VALUE_BITS-1:0] slots_q [DEPTH];
  logic [VALUE_BITS-1:0] slots_d [DEPTH];
  logic [CNT_W-1:0]      count_q, count_d;
  logic [2:0]            func_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [DEPTH-1:0]      match_q, match_d;
  logic [DEPTH-1:0]      valid_mask;
  logic [DEPTH-1:0]      first_hit;
  logic [DEPTH-1:0]      keep;
  logic [1:0]            status_q, status_d;
  logic                  found_q, found_d;
  logic                  empty, full;
  logic [IDX_W-1:0]      back_idx;

  assign empty     = (count_q == '0);
  assign full      = (count_q == CNT_W'(DEPTH));
  assign first_hit = match_q & (~match_q + DEPTH'(1));
  assign keep      = first_hit - DEPTH'(1);
  assign back_idx  = IDX_W'(count_q - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_mask[i] = (CNT_W'(i) < count_q);
      match_d[i]    = valid_mask[i] && (slots_q[i] == value_q);
    end
  end

  always_comb begin
    slots_d  = slots_q;
    count_d  = count_q;
    status_d = StOk;
    found_d  = 1'b0;
    unique case (func_q)
      FuncPushFront: begin
        if (full) begin
          status_d = StFull;
        end else begin
          slots_d[0] = value_q;
          for (int i = 1; i < DEPTH; i++) begin
            slots_d[i] = slots_q[i-1];
          end
          count_d = count_q + CNT_W'(1);
        end
      end
      FuncPushBack: begin
        if (full) begin
          status_d = StFull;
        end else begin
          slots_d[count_q[IDX_W-1:0]] = value_q;
          count_d = count_q + CNT_W'(1);
        end
      end
      FuncPopFront: begin
        if (empty) begin
          status_d = StEmpty;
        end else begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            slots_d[i] = slots_q[i+1];
          end
          count_d = count_q - CNT_W'(1);
        end
      end
      FuncPopBack: begin
        if (empty) begin
          status_d = StEmpty;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      FuncContains: begin
        if (empty) begin
          status_d = StEmpty;
        end else begin
          found_d = |match_q;
        end
      end
      FuncRemove: begin
        if (empty) begin
          status_d = StEmpty;
        end else if (|match_q) begin
          found_d = 1'b1;
          for (int i = 0; i < DEPTH - 1; i++) begin
            slots_d[i] = keep[i] ? slots_q[i] : slots_q[i+1];
          end
          count_d = count_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      value_q <= data_value_i;
    end
    if (cmd_i.cmp) begin
      match_q <= match_d;
    end
    if (cmd_i.apply) begin
      slots_q  <= slots_d;
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.apply) begin
      count_q <= count_d;
    end
  end

  assign status_o      = status_q;
  assign found_o       = found_q;
  assign entry_count_o = count_q;
  assign front_value_o = empty ? '0 : slots_q[0];
  assign back_value_o  = empty ? '0 : slots_q[back_idx];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.apply |=> $stable(count_q))
    else $error("entry count changed outside apply");

  a_match_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply |-> (match_q & ~valid_mask) == '0)
    else $error("match flagged beyond stored entries");

endmodule

>>> tb/bounded_deque_with_search_unit_tb.sv
// Testbench for bounded_deque_with_search_unit: random and directed deque operations,
// results checked against an in-bench deque that tracks the same operations.
// Depends on bdq_pkg and the RTL top level only.
`timescale 1ns / 1ps

module bounded_deque_with_search_unit_tb;
  import bdq_pkg::*;

  localparam logic [2:0] FuncUnused6 = 3'd6;
  localparam logic [2:0] FuncUnused7 = 3'd7;
  localparam int         ItemTarget  = 750;
  localparam int         QuietTail   = 100;
  localparam int         LongHold    = 60;
  localparam int         CycleLimit  = 200000;

  typedef struct {
    logic [2:0]            op;
    logic [VALUE_BITS-1:0] value;
    bit                    wait_drain;
  } deque_op_t;

  typedef struct packed {
    logic [1:0]            status;
    logic                  found;
    logic [VALUE_BITS-1:0] front;
    logic [VALUE_BITS-1:0] back;
    logic [CNT_W-1:0]      count;
  } deque_view_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [2:0]            func_i = '0;
  logic [VALUE_BITS-1:0] data_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [1:0]            status_o;
  logic                  found_o;
  logic [VALUE_BITS-1:0] front_value_o;
  logic [VALUE_BITS-1:0] back_value_o;
  logic [CNT_W-1:0]      entry_count_o;

  deque_op_t             op_queue[$];
  deque_view_t           deque_views_q[$];
  logic [VALUE_BITS-1:0] deq_cells[DEPTH];
  int                    deq_len = 0;
  int                    total_items = 0;
  int                    items_sent = 0;
  int                    accepted_cnt = 0;
  int                    returned_cnt = 0;
  int                    err_cnt = 0;
  int                    idle_left = 0;
  int                    stall_left = 0;
  bit                    hold_done = 1'b0;
  logic [VALUE_BITS-1:0] value_pool[6];

  bounded_deque_with_search_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .data_value_i  (data_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .front_value_o (front_value_o),
    .back_value_o  (back_value_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void drop_cell(input int pos);
    for (int i = pos; i + 1 < deq_len; i++) deq_cells[i] = deq_cells[i + 1];
    deq_len--;
  endfunction

  function automatic deque_view_t apply_deque_op(input logic [2:0] op,
                                                 input logic [VALUE_BITS-1:0] v);
    deque_view_t r;
    int hit;
    r = '0;
    r.status = StOk;
    hit = -1;
    case (op)
      FuncPushFront: begin
        if (deq_len >= DEPTH) begin
          r.status = StFull;
        end else begin
          for (int i = deq_len; i > 0; i--) deq_cells[i] = deq_cells[i - 1];
          deq_cells[0] = v;
          deq_len++;
        end
      end
      FuncPushBack: begin
        if (deq_len >= DEPTH) begin
          r.status = StFull;
        end else begin
          deq_cells[deq_len] = v;
          deq_len++;
        end
      end
      FuncPopFront: begin
        if (deq_len == 0) r.status = StEmpty;
        else drop_cell(0);
      end
      FuncPopBack: begin
        if (deq_len == 0) r.status = StEmpty;
        else deq_len--;
      end
      FuncContains, FuncRemove: begin
        if (deq_len == 0) begin
          r.status = StEmpty;
        end else begin
          for (int i = 0; i < deq_len; i++) begin
            if (hit < 0 && deq_cells[i] == v) hit = i;
          end
          r.found = (hit >= 0);
          if (op == FuncRemove && hit >= 0) drop_cell(hit);
        end
      end
      default: ;
    endcase
    if (deq_len != 0) begin
      r.front = deq_cells[0];
      r.back  = deq_cells[deq_len - 1];
    end
    r.count = CNT_W'(deq_len);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [VALUE_BITS-1:0] want,
                                      input logic [VALUE_BITS-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      err_cnt++;
    end
  endfunction

  function automatic void add_op(input logic [2:0] op, input logic [VALUE_BITS-1:0] v,
                                 input bit drain = 1'b0);
    deque_op_t item;
    item.op         = op;
    item.value      = v;
    item.wait_drain = drain;
    op_queue.push_back(item);
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return value_pool[$urandom_range(0, 5)];
  endfunction

  function automatic void refresh_pool();
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(0, 4))
        0:       value_pool[i] = {1'b1, {(VALUE_BITS - 1){1'b0}}};
        1:       value_pool[i] = {1'b0, {(VALUE_BITS - 1){1'b1}}};
        2:       value_pool[i] = VALUE_BITS'($urandom_range(0, 3)) - 1'b1;
        default: value_pool[i] = $urandom;
      endcase
    end
  endfunction

  function automatic void build_stimulus();
    int len;
    add_op(FuncPopFront, 32'h0000_0001);
    add_op(FuncPopBack, 32'hFFFF_FFFF);
    add_op(FuncContains, 32'h0000_0000);
    add_op(FuncRemove, 32'h0000_0000);
    add_op(FuncUnused6, 32'h5A5A_A5A5);
    add_op(FuncUnused7, 32'hA5A5_5A5A);
    add_op(FuncPushBack, 32'h7FFF_FFFF);
    add_op(FuncPushFront, 32'h8000_0000);
    add_op(FuncPushBack, 32'hFFFF_FFFF);
    add_op(FuncPushFront, 32'h0000_0000);
    add_op(FuncContains, 32'h8000_0000);
    add_op(FuncContains, 32'h0000_0001);
    add_op(FuncRemove, 32'h0001_2345);
    add_op(FuncRemove, 32'hFFFF_FFFF);
    add_op(FuncPushBack, 32'h0000_0000);
    add_op(FuncRemove, 32'h0000_0000);
    add_op(FuncUnused6, 32'h0F0F_0F0F);
    add_op(FuncPopFront, 32'h0000_0000);
    add_op(FuncPopBack, 32'h0000_0000);
    add_op(FuncPopFront, 32'h0000_0000);
    add_op(FuncPopBack, 32'h0000_0000);

    while (op_queue.size() < ItemTarget) begin
      refresh_pool();
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          len = $urandom_range(14, 22);
          for (int i = 0; i < len; i++) begin
            add_op($urandom_range(0, 1) ? FuncPushFront : FuncPushBack, pick_value());
          end
        end
        5, 6, 7, 8: begin
          len = $urandom_range(0, 1) ? $urandom_range(16, 20) : $urandom_range(2, 8);
          for (int i = 0; i < len; i++) begin
            add_op($urandom_range(0, 1) ? FuncPopFront : FuncPopBack, $urandom);
          end
        end
        9, 10, 11, 12, 13, 14: begin
          len = $urandom_range(3, 10);
          for (int i = 0; i < len; i++) begin
            add_op($urandom_range(0, 1) ? FuncContains : FuncRemove, pick_value());
          end
        end
        15, 16, 17: begin
          len = $urandom_range(4, 12);
          for (int i = 0; i < len; i++) add_op(3'($urandom_range(0, 5)), pick_value());
        end
        default: begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) add_op(3'($urandom_range(0, 7)), $urandom);
        end
      endcase
    end
    op_queue[21].wait_drain = 1'b1;
    op_queue[op_queue.size() / 2].wait_drain = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_op_t item;
    bit        quiet;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      func_i       <= '0;
      data_value_i <= '0;
      idle_left    = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      quiet = (items_sent >= total_items - QuietTail) || ((items_sent / 50) % 3 == 1);
      if (idle_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(1, 4);
      end
      if (idle_left > 0) begin
        idle_left--;
        in_valid_i <= 1'b0;
      end else if (op_queue.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (op_queue[0].wait_drain && (in_valid_i || accepted_cnt != returned_cnt)) begin
        in_valid_i <= 1'b0;
      end else begin
        item = op_queue.pop_front();
        in_valid_i   <= 1'b1;
        func_i       <= item.op;
        data_value_i <= item.value;
        items_sent++;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
      hold_done   = 1'b0;
    end else begin
      if (!hold_done && accepted_cnt >= 200) begin
        hold_done  = 1'b1;
        stall_left = LongHold;
      end else if (stall_left == 0 && returned_cnt < total_items - QuietTail &&
                   (accepted_cnt / 50) % 3 != 2 && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    deque_view_t want;
    if (!rst_ni) begin
      accepted_cnt <= 0;
      returned_cnt <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        returned_cnt <= returned_cnt + 1;
        if (deque_views_q.size() == 0) begin
          $error("result with no pending transaction");
          err_cnt++;
        end else begin
          want = deque_views_q.pop_front();
          check_field("status", VALUE_BITS'(want.status), VALUE_BITS'(status_o));
          check_field("found", VALUE_BITS'(want.found), VALUE_BITS'(found_o));
          check_field("front_value", want.front, front_value_o);
          check_field("back_value", want.back, back_value_o);
          check_field("entry_count", VALUE_BITS'(want.count), VALUE_BITS'(entry_count_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        deque_views_q.push_back(apply_deque_op(func_i, data_value_i));
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("bounded_deque_with_search_unit_tb: done, errors");
    $finish;
  end

  initial begin
    build_stimulus();
    total_items = op_queue.size();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(accepted_cnt == total_items && returned_cnt == accepted_cnt)) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("bounded_deque_with_search_unit_tb: done, clean");
    end else begin
      $display("bounded_deque_with_search_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
